[rtl/ils_pkg.sv]
// ----------------------------------------------------------------------------
// ils_pkg
// Types and codes shared by the indexed list store and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_BACK   = 3'd3;
    localparam logic [2:0] MODE_READ_AT    = 3'd4;
    localparam logic [2:0] MODE_INSERT_AT  = 3'd5;
    localparam logic [2:0] MODE_ERASE_AT   = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  position;
        logic [31:0] payload;
    } ils_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_value;
        logic [6:0]  length;
    } ils_rsp_t;

endpackage

`default_nettype wire

[rtl/indexed_list_store.sv]
// ----------------------------------------------------------------------------
// indexed_list_store
// Bounded ordered list with push, pop, read, insert and erase by position.
// ----------------------------------------------------------------------------
// Usage:
//   A request item (mode, position, payload) enters on req when req_valid
//   is high and req_stall low. Each request gives exactly one response item
//   (status, read_value, length) on rsp, taken when rsp_valid is high and
//   rsp_stall low. One request is in work at a time.
//   The elements sit in order in one RAM. Insert and push_front shift the tail up
//   by one slot and erase and a front pop shift it down, one element per
//   cycle through the RAM's read and write ports.
//   Path to the response: push_back, pop_back, appends, erasing the last
//   element and rejected requests register it on acceptance; read_at
//   passes through S_READ_WAIT; a shifting insert runs S_SHIFT_UP down to
//   the insertion slot, then S_WRITE_INS; a shifting erase runs S_SHIFT_DN.
//   The longest path is push_front on a list one short of full.
//   A new request is taken once the previous response has been taken, or in
//   the cycle it is taken. While rsp_stall is high the response holds.
//   Reset empties the list; the RAM needs no clearing since only slots
//   below the length are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store
    import ils_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire ils_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output ils_rsp_t      rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_UP,
        S_WRITE_INS,
        S_SHIFT_DN,
        S_READ_WAIT
    } state_t;

    state_t           state_reg;
    logic [CW-1:0]    count_reg;
    logic [AW-1:0]    src_reg;
    logic [AW-1:0]    at_reg;
    logic [AW-1:0]    last_reg;
    logic [DATA_WIDTH-1:0] pay_reg;
    logic             rsp_valid_reg;
    ils_rsp_t         rsp_reg;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic                  present;
    logic                  rsp_fire;
    logic [CW-1:0]         ins_at;
    logic [CW-1:0]         rem_at;
    logic [CW-1:0]         count_m1;
    logic [DATA_WIDTH-1:0] pay_in;
    logic [31:0]           rd_out;

    generate
        if (DATA_WIDTH <= 32)
        begin : g_narrow
            assign pay_in = req.payload[DATA_WIDTH-1:0];
            assign rd_out = {{(32 - DATA_WIDTH){1'b0}}, ram_rdata};
        end
        else
        begin : g_wide
            assign pay_in = {{(DATA_WIDTH - 32){1'b0}}, req.payload};
            assign rd_out = ram_rdata[31:0];
        end
    endgenerate

    assign req_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg >= CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign present   = (PW'(req.position) < PW'(count_reg));
    assign count_m1  = count_reg - CW'(1);

    always_comb
    begin
        case (req.mode)
            MODE_PUSH_FRONT: ins_at = '0;
            MODE_INSERT_AT:  ins_at = present ? CW'(req.position) : count_reg;
            default:         ins_at = count_reg;
        endcase
        rem_at = (req.mode == MODE_ERASE_AT) ? CW'(req.position) : '0;
    end

    // The response item is ready at the end of this cycle.
    always_comb
    begin
        rsp_fire = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.mode)
                        MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT_AT:
                        begin
                            rsp_fire = full || (ins_at == count_reg);
                        end
                        MODE_POP_FRONT, MODE_ERASE_AT:
                        begin
                            rsp_fire = ((req.mode == MODE_POP_FRONT) ? empty : !present)
                                       || (rem_at == count_m1);
                        end
                        MODE_READ_AT:
                        begin
                            rsp_fire = !present;
                        end
                        default:
                        begin
                            rsp_fire = 1'b1;
                        end
                    endcase
                end
            end
            S_WRITE_INS, S_READ_WAIT:
            begin
                rsp_fire = 1'b1;
            end
            S_SHIFT_DN:
            begin
                rsp_fire = (src_reg == last_reg);
            end
            default:
            begin
                rsp_fire = 1'b0;
            end
        endcase
    end

    // RAM port control.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = pay_reg;
        ram_raddr = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.mode)
                        MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT_AT:
                        begin
                            if (!full && ins_at == count_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(ins_at);
                                ram_wdata = pay_in;
                            end
                            ram_raddr = AW'(count_m1);
                        end
                        MODE_POP_FRONT, MODE_ERASE_AT:
                        begin
                            ram_raddr = AW'(rem_at + CW'(1));
                        end
                        MODE_READ_AT:
                        begin
                            ram_raddr = AW'(req.position);
                        end
                        default:
                        begin
                            ram_raddr = '0;
                        end
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = src_reg + AW'(1);
                ram_wdata = ram_rdata;
                ram_raddr = src_reg - AW'(1);
            end
            S_WRITE_INS:
            begin
                ram_we    = 1'b1;
                ram_waddr = at_reg;
                ram_wdata = pay_reg;
            end
            S_SHIFT_DN:
            begin
                ram_we    = 1'b1;
                ram_waddr = src_reg - AW'(1);
                ram_wdata = ram_rdata;
                ram_raddr = src_reg + AW'(1);
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    ils_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(CAPACITY)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_fire || (rsp_valid_reg && rsp_stall);
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        rsp_reg.read_value <= '0;
                        pay_reg            <= pay_in;
                        at_reg             <= AW'(ins_at);
                        case (req.mode)
                            MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT_AT:
                            begin
                                if (full)
                                begin
                                    rsp_reg.status <= ST_FULL;
                                    rsp_reg.length <= 7'(count_reg);
                                end
                                else
                                begin
                                    rsp_reg.status <= ST_OK;
                                    count_reg      <= count_reg + CW'(1);
                                    rsp_reg.length <= 7'(count_reg + CW'(1));
                                    if (ins_at != count_reg)
                                    begin
                                        src_reg   <= AW'(count_m1);
                                        state_reg <= S_SHIFT_UP;
                                    end
                                end
                            end
                            MODE_POP_FRONT, MODE_ERASE_AT:
                            begin
                                if ((req.mode == MODE_POP_FRONT) ? empty : !present)
                                begin
                                    rsp_reg.status <= ST_ABSENT;
                                    rsp_reg.length <= 7'(count_reg);
                                end
                                else
                                begin
                                    rsp_reg.status <= ST_OK;
                                    count_reg      <= count_m1;
                                    rsp_reg.length <= 7'(count_m1);
                                    if (rem_at != count_m1)
                                    begin
                                        src_reg   <= AW'(rem_at + CW'(1));
                                        last_reg  <= AW'(count_m1);
                                        state_reg <= S_SHIFT_DN;
                                    end
                                end
                            end
                            MODE_POP_BACK:
                            begin
                                if (empty)
                                begin
                                    rsp_reg.status <= ST_ABSENT;
                                    rsp_reg.length <= 7'(count_reg);
                                end
                                else
                                begin
                                    rsp_reg.status <= ST_OK;
                                    count_reg      <= count_m1;
                                    rsp_reg.length <= 7'(count_m1);
                                end
                            end
                            MODE_READ_AT:
                            begin
                                rsp_reg.length <= 7'(count_reg);
                                if (present)
                                begin
                                    rsp_reg.status <= ST_OK;
                                    state_reg      <= S_READ_WAIT;
                                end
                                else
                                begin
                                    rsp_reg.status <= ST_ABSENT;
                                end
                            end
                            default:
                            begin
                                rsp_reg.status <= ST_ABSENT;
                                rsp_reg.length <= 7'(count_reg);
                            end
                        endcase
                    end
                end
                S_SHIFT_UP:
                begin
                    // The slot just moved up was the insertion slot: fill it next.
                    if (src_reg == at_reg)
                    begin
                        state_reg <= S_WRITE_INS;
                    end
                    else
                    begin
                        src_reg <= src_reg - AW'(1);
                    end
                end
                S_WRITE_INS:
                begin
                    state_reg <= S_IDLE;
                end
                S_SHIFT_DN:
                begin
                    if (src_reg == last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        src_reg <= src_reg + AW'(1);
                    end
                end
                S_READ_WAIT:
                begin
                    rsp_reg.read_value <= rd_out;
                    state_reg          <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[rtl/ils_ram.sv]
// ----------------------------------------------------------------------------
// ils_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/ils_checker.sv]
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks on the indexed list store's responses.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_checker
    import ils_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     req_valid,
    input wire logic     req_stall,
    input wire logic     rsp_valid,
    input wire logic     rsp_stall,
    input wire ils_rsp_t rsp
);

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status != 2'd3))
        else $error("response status outside its codes");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_FULL) |-> (rsp.length == 7'(CAPACITY)))
        else $error("full reported on a list that is not full");

    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.read_value != '0) |-> (rsp.status == ST_OK))
        else $error("read value given with a failing status");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");

    // A response item held by the receiver blocks new requests.
    a_req_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |-> !(rsp_valid && rsp_stall))
        else $error("request taken while a response item was stalled");

endmodule

bind indexed_list_store ils_checker #(.CAPACITY(CAPACITY)) u_ils_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
);

`default_nettype wire

[tb/indexed_list_store_checker.sv]
// ----------------------------------------------------------------------------
// indexed_list_store_checker
// Watches both channels of the indexed list store, keeps its own copy of the
// list, works out the response to every accepted request and compares it
// with the response item that the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store_checker
    import ils_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    input  wire logic     req_stall,
    input  wire ils_req_t req,
    input  wire logic     rsp_valid,
    input  wire logic     rsp_stall,
    input  wire ils_rsp_t rsp,
    output int            fail_count,
    output int            pending_count,
    output int            rsp_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] list_words[$];
    ils_rsp_t    expected_rsps[$];

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count = fail_count + 1;
    endtask

    // Applies one request to the list copy and returns the response it gives.
    function automatic ils_rsp_t apply_request(input ils_req_t r);
        ils_rsp_t res;
        int       n;
        logic     full;
        logic     present;
        n = list_words.size();
        full = (n >= CAPACITY);
        present = (int'(r.position) < n);
        res.status = ST_OK;
        res.read_value = '0;
        case (r.mode)
            MODE_PUSH_FRONT:
                if (full) res.status = ST_FULL;
                else list_words.push_front(r.payload);
            MODE_PUSH_BACK:
                if (full) res.status = ST_FULL;
                else list_words.push_back(r.payload);
            MODE_POP_FRONT:
                if (n == 0) res.status = ST_ABSENT;
                else list_words.delete(0);
            MODE_POP_BACK:
                if (n == 0) res.status = ST_ABSENT;
                else list_words.delete(n - 1);
            MODE_READ_AT:
                if (present) res.read_value = list_words[r.position];
                else res.status = ST_ABSENT;
            MODE_INSERT_AT:
                if (full) res.status = ST_FULL;
                else if (present) list_words.insert(r.position, r.payload);
                else list_words.push_back(r.payload);
            MODE_ERASE_AT:
                if (present) list_words.delete(r.position);
                else res.status = ST_ABSENT;
            default:
                res.status = ST_ABSENT;
        endcase
        res.length = 7'(list_words.size());
        return res;
    endfunction

    initial
    begin
        fail_count = 0;
        pending_count = 0;
        rsp_count = 0;
    end

    always @(posedge clk)
    begin
        ils_rsp_t want;
        if (rst_n)
        begin
            // The response is checked first: a request taken in the same
            // cycle cannot have produced it.
            if (rsp_valid && !rsp_stall)
            begin
                rsp_count = rsp_count + 1;
                if (expected_rsps.size() == 0)
                    report_mismatch("response item with none expected");
                else
                begin
                    want = expected_rsps[0];
                    expected_rsps.delete(0);
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  rsp.status, want.status));
                    if (rsp.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value %h, expected %h",
                                                  rsp.read_value, want.read_value));
                    if (rsp.length !== want.length)
                        report_mismatch($sformatf("length %0d, expected %0d",
                                                  rsp.length, want.length));
                end
            end
            if (req_valid && !req_stall)
                expected_rsps.push_back(apply_request(req));
            pending_count = expected_rsps.size();
        end
    end

endmodule

`default_nettype wire

[tb/indexed_list_store_test.sv]
// ----------------------------------------------------------------------------
// indexed_list_store_test
// Drives request items into the indexed list store with random gaps and
// random response stalls: a directed opening over every operation and edge,
// then random runs that fill the list to capacity and drain it again.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store_test;
    import ils_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = 64;
    localparam int IDLE_LIMIT = 2000;

    typedef logic bool_t;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    ils_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    ils_rsp_t rsp;
    int       fail_count;
    int       pending_count;
    int       rsp_count;
    int       idle_cycles;
    int       length_model;
    int       sent_count;
    int       full_hits;
    int       empty_hits;

    indexed_list_store #(.CAPACITY(CAPACITY), .DATA_WIDTH(32)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    indexed_list_store_checker #(.CAPACITY(CAPACITY)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .fail_count(fail_count), .pending_count(pending_count),
        .rsp_count(rsp_count)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Watchdog on cycles with no accepted item on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("indexed_list_store_test failed");
            $finish;
        end
    end

    // The receiving side stalls for a random number of cycles before each
    // response item; at least one item in four is taken with no stall at all.
    initial
    begin
        int hold;
        rsp_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            hold = ($urandom_range(3) == 0) ? 0 : $urandom_range(14);
            repeat (hold) @(negedge clk);
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
            @(negedge clk);
            rsp_stall <= 1'b1;
        end
    end

    // Tracks the length the list should have, to steer the random part.
    function automatic int next_length(input ils_req_t r, input int n);
        case (r.mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT_AT:
                return (n < CAPACITY) ? n + 1 : n;
            MODE_POP_FRONT, MODE_POP_BACK:
                return (n > 0) ? n - 1 : n;
            MODE_ERASE_AT:
                return (int'(r.position) < n) ? n - 1 : n;
            default:
                return n;
        endcase
    endfunction

    task automatic send_request(input logic [2:0] mode, input logic [7:0] position,
                                input logic [31:0] payload, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(14);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.mode <= mode;
        req.position <= position;
        req.payload <= payload;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        if (length_model == CAPACITY) full_hits++;
        if (length_model == 0) empty_hits++;
        length_model = next_length('{mode, position, payload}, length_model);
        sent_count++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Positions mostly inside the list, some at its end and some far past it.
    function automatic logic [7:0] rand_position(input int n);
        case ($urandom_range(9))
            0: return 8'(n);
            1: return 8'($urandom_range(255));
            2: return 8'd255;
            default: return (n > 0) ? 8'($urandom_range(n - 1)) : 8'd0;
        endcase
    endfunction

    initial
    begin
        int       phase_len;
        bool_t    grow;
        logic [2:0] m;
        bit       burst;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        length_model = 0;
        sent_count = 0;
        full_hits = 0;
        empty_hits = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-list cases, every operation, edge positions.
        send_request(MODE_POP_FRONT, 8'd0, 32'h0, 1'b0);
        send_request(MODE_POP_BACK, 8'd0, 32'h0, 1'b0);
        send_request(MODE_READ_AT, 8'd0, 32'h0, 1'b0);
        send_request(MODE_ERASE_AT, 8'd0, 32'h0, 1'b0);
        send_request(MODE_PUSH_BACK, 8'd0, 32'hFFFF_FFFF, 1'b0);
        send_request(MODE_PUSH_FRONT, 8'd0, 32'h0000_0000, 1'b0);
        send_request(MODE_INSERT_AT, 8'd0, 32'hA5A5_5A5A, 1'b1);
        send_request(MODE_INSERT_AT, 8'd255, 32'h5A5A_A5A5, 1'b1);
        send_request(MODE_INSERT_AT, 8'd2, 32'h1234_5678, 1'b0);
        send_request(MODE_READ_AT, 8'd0, 32'hFFFF_FFFF, 1'b0);
        send_request(MODE_READ_AT, 8'd4, 32'h0, 1'b0);
        send_request(MODE_READ_AT, 8'd5, 32'h0, 1'b0);
        send_request(MODE_READ_AT, 8'd255, 32'h0, 1'b0);
        send_request(3'd7, 8'd255, 32'hFFFF_FFFF, 1'b0);
        send_request(MODE_ERASE_AT, 8'd5, 32'h0, 1'b0);
        send_request(MODE_ERASE_AT, 8'd2, 32'h0, 1'b0);
        send_request(MODE_ERASE_AT, 8'd0, 32'h0, 1'b0);
        send_request(MODE_POP_FRONT, 8'd0, 32'h0, 1'b0);
        send_request(MODE_POP_BACK, 8'd0, 32'h0, 1'b0);
        send_request(MODE_READ_AT, 8'd0, 32'h0, 1'b0);

        // Random: phases that push the list towards full or towards empty,
        // with the content and positions random and some invalid modes.
        grow = 1'b1;
        while (sent_count < 1080)
        begin
            phase_len = $urandom_range(20, 120);
            burst = ($urandom_range(3) == 0);
            repeat (phase_len)
            begin
                case ($urandom_range(9))
                    0, 1, 2: m = grow ? 3'($urandom_range(1)) : 3'($urandom_range(2, 3));
                    3, 4: m = grow ? MODE_INSERT_AT : MODE_ERASE_AT;
                    5, 6: m = MODE_READ_AT;
                    7: m = ($urandom_range(7) == 0) ? 3'd7 : 3'($urandom_range(6));
                    default: m = grow ? MODE_INSERT_AT : 3'($urandom_range(2, 3));
                endcase
                send_request(m, rand_position(length_model), rand_word(), burst);
            end
            if (length_model == CAPACITY) grow = 1'b0;
            else if (length_model == 0) grow = 1'b1;
            else if ($urandom_range(3) == 0) grow = !grow;
        end
        req_valid <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);

        $display("%0d requests sent, %0d responses checked", sent_count, rsp_count);
        $display("requests on a full list: %0d, on an empty list: %0d",
                 full_hits, empty_hits);
        if (fail_count == 0)
            $display("indexed_list_store_test passed");
        else
            $display("indexed_list_store_test failed");
        $finish;
    end

endmodule

`default_nettype wire
